// ----- design/dcr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared types and constants of the two-disc collision response pipeline.
// ----------------------------------------------------------------------------
package dcr_pkg;

    localparam int DIV_QW = 34;   // quotient bits of all three dividers
    localparam int Q_NW   = 62;   // |dot| * |pn| numerator
    localparam int Q_DW   = 29;   // pn.pn denominator
    localparam int M_NW   = 63;   // m2 << 31 numerator
    localparam int M_DW   = 33;   // m1 + m2 denominator

    localparam logic [15:0] E_ONE   = 16'd32768;
    localparam logic [31:0] F_ONE   = 32'h8000_0000;
    localparam logic [31:0] F_HALF  = 32'h4000_0000;

    typedef struct packed {
        logic signed [31:0] c1x;
        logic signed [31:0] c1y;
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic        [30:0] r1;
        logic signed [31:0] c2x;
        logic signed [31:0] c2y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
        logic        [30:0] r2;
    } t_pair;

    typedef struct packed {
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
    } t_vel;

    typedef struct packed {
        t_vel               vel;
        logic signed [32:0] vx;
        logic signed [32:0] vy;
        logic               appr;
        logic               sgnx;
    } t_carry;

    typedef struct packed {
        t_carry              carry;
        logic [Q_NW-1:0]     nqx;
        logic [Q_NW-1:0]     nqy;
        logic [Q_DW-1:0]     dq;
        logic [M_NW-1:0]     nm;
        logic [M_DW-1:0]     dm;
        logic                sgny;
        logic                mzero;
    } t_front;

    typedef struct packed {
        logic        appr;
        logic [31:0] n1x;
        logic [31:0] n1y;
        logic [31:0] n2x;
        logic [31:0] n2y;
    } t_result;

    function automatic logic [31:0] f_sat32(input logic signed [39:0] x);
        logic [31:0] y;
        if (x > 40'sd2147483647) begin
            y = 32'h7FFF_FFFF;
        end else if (x < -40'sd2147483648) begin
            y = 32'h8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

// ----- design/dcr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_front
// Seven stages: differences, magnitudes, direction normalize and radius
// scaling, products, dot and mass sums, dot magnitude, divider numerators.
// ----------------------------------------------------------------------------
module dcr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  dcr_pkg::t_pair  i_pair,
    output logic            o_valid,
    output dcr_pkg::t_front o_front
);
    import dcr_pkg::*;

    function automatic logic [5:0] f_msb(input logic [32:0] x);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 33; i++) begin
            if (x[i]) p = 6'(i);
        end
        return p;
    endfunction

    // stage 1
    logic               r1_vld;
    logic signed [32:0] r1_px, r1_py, r1_vx, r1_vy;
    t_vel               r1_vel;
    logic        [30:0] r1_r1, r1_r2;
    // stage 2
    logic               r2_vld;
    logic        [32:0] r2_ax, r2_ay, r2_mx;
    logic               r2_nx, r2_ny;
    logic        [30:0] r2_r1, r2_r2, r2_rmax;
    logic signed [32:0] r2_vx, r2_vy;
    t_vel               r2_vel;
    // stage 3
    logic               r3_vld;
    logic        [13:0] r3_apx, r3_apy;
    logic               r3_nx, r3_ny;
    logic        [15:0] r3_r1, r3_r2;
    logic signed [32:0] r3_vx, r3_vy;
    t_vel               r3_vel;
    // stage 4
    logic               r4_vld;
    logic signed [47:0] r4_pvx, r4_pvy;
    logic        [27:0] r4_ppx, r4_ppy;
    logic        [31:0] r4_m1, r4_m2;
    logic        [13:0] r4_apx, r4_apy;
    logic               r4_nx, r4_ny;
    logic signed [32:0] r4_vx, r4_vy;
    t_vel               r4_vel;
    // stage 5
    logic               r5_vld;
    logic signed [48:0] r5_dot;
    logic        [28:0] r5_pp;
    logic        [32:0] r5_msum;
    logic        [31:0] r5_m2;
    logic        [13:0] r5_apx, r5_apy;
    logic               r5_nx, r5_ny;
    logic signed [32:0] r5_vx, r5_vy;
    t_vel               r5_vel;
    // stage 6
    logic               r6_vld;
    logic        [47:0] r6_adot;
    logic               r6_appr, r6_sgnx, r6_sgny;
    logic        [28:0] r6_pp;
    logic        [32:0] r6_msum;
    logic        [31:0] r6_m2;
    logic        [13:0] r6_apx, r6_apy;
    logic signed [32:0] r6_vx, r6_vy;
    t_vel               r6_vel;
    // stage 7
    logic               r7_vld;
    t_front             r7_out;

    logic        [32:0] n2_ax, n2_ay;
    logic        [5:0]  w_msb, w_rmsb;
    logic        [13:0] n3_apx, n3_apy;
    logic        [15:0] n3_r1, n3_r2;
    logic signed [14:0] w_pnx, w_pny;
    logic        [47:0] n6_adot;
    logic signed [48:0] w_ndot;

    assign n2_ax = r1_px[32] ? 33'(-r1_px) : 33'(r1_px);
    assign n2_ay = r1_py[32] ? 33'(-r1_py) : 33'(r1_py);

    assign w_msb  = f_msb(r2_mx);
    assign w_rmsb = f_msb(33'(r2_rmax));

    always_comb begin
        n3_apx = '0;
        n3_apy = '0;
        if (r2_mx != 33'd0) begin
            if (w_msb >= 6'd13) begin
                n3_apx = 14'(r2_ax >> (w_msb - 6'd13));
                n3_apy = 14'(r2_ay >> (w_msb - 6'd13));
            end else begin
                n3_apx = 14'(r2_ax << (6'd13 - w_msb));
                n3_apy = 14'(r2_ay << (6'd13 - w_msb));
            end
        end
        n3_r1 = r2_r1[15:0];
        n3_r2 = r2_r2[15:0];
        if (w_rmsb >= 6'd16) begin
            n3_r1 = 16'(r2_r1 >> (w_rmsb - 6'd15));
            n3_r2 = 16'(r2_r2 >> (w_rmsb - 6'd15));
        end
    end

    assign w_pnx = r3_nx ? -$signed({1'b0, r3_apx}) : $signed({1'b0, r3_apx});
    assign w_pny = r3_ny ? -$signed({1'b0, r3_apy}) : $signed({1'b0, r3_apy});

    assign w_ndot  = -r5_dot;
    assign n6_adot = r5_dot[48] ? w_ndot[47:0] : r5_dot[47:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_px   <= 33'(i_pair.c2x) - 33'(i_pair.c1x);
            r1_py   <= 33'(i_pair.c2y) - 33'(i_pair.c1y);
            r1_vx   <= 33'(i_pair.v2x) - 33'(i_pair.v1x);
            r1_vy   <= 33'(i_pair.v2y) - 33'(i_pair.v1y);
            r1_vel  <= '{v1x: i_pair.v1x, v1y: i_pair.v1y,
                         v2x: i_pair.v2x, v2y: i_pair.v2y};
            r1_r1   <= i_pair.r1;
            r1_r2   <= i_pair.r2;

            r2_ax   <= n2_ax;
            r2_ay   <= n2_ay;
            r2_mx   <= (n2_ax > n2_ay) ? n2_ax : n2_ay;
            r2_nx   <= r1_px[32];
            r2_ny   <= r1_py[32];
            r2_r1   <= r1_r1;
            r2_r2   <= r1_r2;
            r2_rmax <= (r1_r1 > r1_r2) ? r1_r1 : r1_r2;
            r2_vx   <= r1_vx;
            r2_vy   <= r1_vy;
            r2_vel  <= r1_vel;

            r3_apx  <= n3_apx;
            r3_apy  <= n3_apy;
            r3_nx   <= r2_nx;
            r3_ny   <= r2_ny;
            r3_r1   <= n3_r1;
            r3_r2   <= n3_r2;
            r3_vx   <= r2_vx;
            r3_vy   <= r2_vy;
            r3_vel  <= r2_vel;

            r4_pvx  <= w_pnx * r3_vx;
            r4_pvy  <= w_pny * r3_vy;
            r4_ppx  <= r3_apx * r3_apx;
            r4_ppy  <= r3_apy * r3_apy;
            r4_m1   <= r3_r1 * r3_r1;
            r4_m2   <= r3_r2 * r3_r2;
            r4_apx  <= r3_apx;
            r4_apy  <= r3_apy;
            r4_nx   <= r3_nx;
            r4_ny   <= r3_ny;
            r4_vx   <= r3_vx;
            r4_vy   <= r3_vy;
            r4_vel  <= r3_vel;

            r5_dot  <= 49'(r4_pvx) + 49'(r4_pvy);
            r5_pp   <= 29'(r4_ppx) + 29'(r4_ppy);
            r5_msum <= 33'(r4_m1) + 33'(r4_m2);
            r5_m2   <= r4_m2;
            r5_apx  <= r4_apx;
            r5_apy  <= r4_apy;
            r5_nx   <= r4_nx;
            r5_ny   <= r4_ny;
            r5_vx   <= r4_vx;
            r5_vy   <= r4_vy;
            r5_vel  <= r4_vel;

            r6_adot <= n6_adot;
            r6_appr <= r5_dot[48];
            r6_sgnx <= r5_dot[48] ^ r5_nx;
            r6_sgny <= r5_dot[48] ^ r5_ny;
            r6_pp   <= r5_pp;
            r6_msum <= r5_msum;
            r6_m2   <= r5_m2;
            r6_apx  <= r5_apx;
            r6_apy  <= r5_apy;
            r6_vx   <= r5_vx;
            r6_vy   <= r5_vy;
            r6_vel  <= r5_vel;

            r7_out.carry <= '{vel: r6_vel, vx: r6_vx, vy: r6_vy,
                              appr: r6_appr, sgnx: r6_sgnx};
            r7_out.nqx   <= r6_adot * r6_apx;
            r7_out.nqy   <= r6_adot * r6_apy;
            r7_out.dq    <= r6_pp;
            r7_out.nm    <= {r6_m2, 31'd0};
            r7_out.dm    <= r6_msum;
            r7_out.sgny  <= r6_sgny;
            r7_out.mzero <= (r6_msum == 33'd0);
        end
    end

    assign o_valid = r7_vld;
    assign o_front = r7_out;

endmodule

// ----- design/dcr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_div
// Pipelined restoring divider, one quotient bit per stage. The numerator
// must satisfy num < den << QW.
// ----------------------------------------------------------------------------
module dcr_div #(
    parameter int NW = 62,
    parameter int DW = 29,
    parameter int QW = 34,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pl,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic [PW-1:0] o_pl
);

    logic          r_vld [QW];
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_nq  [QW];
    logic [DW-1:0] r_den [QW];
    logic [PW-1:0] r_pl  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          w_vld_in;
        logic [DW-1:0] w_rem_in;
        logic [QW-1:0] w_nq_in;
        logic [DW-1:0] w_den_in;
        logic [PW-1:0] w_pl_in;
        logic [DW:0]   w_t;
        logic [DW:0]   w_diff;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_vld_in = i_valid;
            assign w_rem_in = DW'(i_num[NW-1:QW]);
            assign w_nq_in  = i_num[QW-1:0];
            assign w_den_in = i_den;
            assign w_pl_in  = i_pl;
        end else begin : g_next
            assign w_vld_in = r_vld[k-1];
            assign w_rem_in = r_rem[k-1];
            assign w_nq_in  = r_nq[k-1];
            assign w_den_in = r_den[k-1];
            assign w_pl_in  = r_pl[k-1];
        end

        assign w_t    = {w_rem_in, w_nq_in[QW-1]};
        assign w_diff = w_t - {1'b0, w_den_in};
        assign w_ge   = (w_t >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
                r_nq[k]  <= {w_nq_in[QW-2:0], w_ge};
                r_den[k] <= w_den_in;
                r_pl[k]  <= w_pl_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quot  = r_nq[QW-1];
    assign o_pl    = r_pl[QW-1];

endmodule

// ----- design/dcr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_back
// Six stages: signed quotients and mass fractions, reflected relative
// velocity and gains, centre-of-mass velocity, gain products, saturation.
// ----------------------------------------------------------------------------
module dcr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  dcr_pkg::t_carry             i_carry,
    input  logic [dcr_pkg::DIV_QW-1:0]  i_qx,
    input  logic [dcr_pkg::DIV_QW-1:0]  i_qy,
    input  logic                        i_sgny,
    input  logic [dcr_pkg::DIV_QW-1:0]  i_f2,
    input  logic                        i_mzero,
    input  logic [15:0]                 i_restitution,
    output logic                        o_valid,
    output dcr_pkg::t_result            o_result
);
    import dcr_pkg::*;

    // stage 1
    logic               r1_vld;
    logic signed [34:0] r1_qx, r1_qy;
    logic        [31:0] r1_f1, r1_f2;
    logic        [32:0] r1_avx, r1_avy;
    logic        [15:0] r1_ec;
    t_carry             r1_c;
    // stage 2
    logic               r2_vld;
    logic signed [36:0] r2_wx, r2_wy;
    logic        [31:0] r2_g1, r2_g2;
    logic        [48:0] r2_phx, r2_phy;
    logic        [47:0] r2_plx, r2_ply;
    t_carry             r2_c;
    // stage 3
    logic               r3_vld;
    logic        [36:0] r3_awx, r3_awy;
    logic               r3_swx, r3_swy;
    logic        [34:0] r3_rvx, r3_rvy;
    logic        [31:0] r3_g1, r3_g2;
    t_carry             r3_c;
    // stage 4
    logic               r4_vld;
    logic signed [36:0] r4_cmx, r4_cmy;
    logic        [52:0] r4_h2x, r4_h2y, r4_h1x, r4_h1y;
    logic        [47:0] r4_l2x, r4_l2y, r4_l1x, r4_l1y;
    logic               r4_swx, r4_swy;
    logic               r4_appr;
    t_vel               r4_vel;
    // stage 5
    logic               r5_vld;
    logic signed [36:0] r5_cmx, r5_cmy;
    logic signed [38:0] r5_d2x, r5_d2y, r5_d1x, r5_d1y;
    logic               r5_appr;
    t_vel               r5_vel;
    // stage 6
    logic               r6_vld;
    t_result            r6_res;

    logic [47:0] w_eg1, w_eg2;
    logic [65:0] w_svx, w_svy;
    logic [68:0] w_s2x, w_s2y, w_s1x, w_s1y;

    function automatic logic signed [38:0] f_sgn(input logic s, input logic [37:0] m);
        logic signed [38:0] v;
        v = $signed({1'b0, m});
        return s ? -v : v;
    endfunction

    function automatic logic signed [36:0] f_cm(input logic signed [31:0] v1,
                                                input logic s, input logic [34:0] m);
        logic signed [36:0] d;
        d = $signed({2'b00, m});
        return 37'(v1) + (s ? -d : d);
    endfunction

    assign w_eg1 = r1_ec * r1_f1;
    assign w_eg2 = r1_ec * r1_f2;
    assign w_svx = {r2_phx, 16'd0} + 66'(r2_plx);
    assign w_svy = {r2_phy, 16'd0} + 66'(r2_ply);
    assign w_s2x = {r4_h2x, 16'd0} + 69'(r4_l2x);
    assign w_s2y = {r4_h2y, 16'd0} + 69'(r4_l2y);
    assign w_s1x = {r4_h1x, 16'd0} + 69'(r4_l1x);
    assign w_s1y = {r4_h1y, 16'd0} + 69'(r4_l1y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_qx  <= i_carry.sgnx ? -$signed({1'b0, i_qx}) : $signed({1'b0, i_qx});
            r1_qy  <= i_sgny ? -$signed({1'b0, i_qy}) : $signed({1'b0, i_qy});
            r1_f2  <= i_mzero ? F_HALF : i_f2[31:0];
            r1_f1  <= F_ONE - (i_mzero ? F_HALF : i_f2[31:0]);
            r1_avx <= i_carry.vx[32] ? 33'(-i_carry.vx) : 33'(i_carry.vx);
            r1_avy <= i_carry.vy[32] ? 33'(-i_carry.vy) : 33'(i_carry.vy);
            r1_ec  <= (i_restitution > E_ONE) ? E_ONE : i_restitution;
            r1_c   <= i_carry;

            r2_wx  <= (37'(r1_qx) <<< 1) - 37'(r1_c.vx);
            r2_wy  <= (37'(r1_qy) <<< 1) - 37'(r1_c.vy);
            r2_g1  <= w_eg1[46:15];
            r2_g2  <= w_eg2[46:15];
            r2_phx <= r1_avx[32:16] * r1_f2;
            r2_phy <= r1_avy[32:16] * r1_f2;
            r2_plx <= r1_avx[15:0] * r1_f2;
            r2_ply <= r1_avy[15:0] * r1_f2;
            r2_c   <= r1_c;

            r3_awx <= r2_wx[36] ? 37'(-r2_wx) : 37'(r2_wx);
            r3_awy <= r2_wy[36] ? 37'(-r2_wy) : 37'(r2_wy);
            r3_swx <= r2_wx[36];
            r3_swy <= r2_wy[36];
            r3_rvx <= w_svx[65:31];
            r3_rvy <= w_svy[65:31];
            r3_g1  <= r2_g1;
            r3_g2  <= r2_g2;
            r3_c   <= r2_c;

            r4_cmx  <= f_cm(r3_c.vel.v1x, r3_c.vx[32], r3_rvx);
            r4_cmy  <= f_cm(r3_c.vel.v1y, r3_c.vy[32], r3_rvy);
            r4_h2x  <= r3_awx[36:16] * r3_g2;
            r4_h2y  <= r3_awy[36:16] * r3_g2;
            r4_h1x  <= r3_awx[36:16] * r3_g1;
            r4_h1y  <= r3_awy[36:16] * r3_g1;
            r4_l2x  <= r3_awx[15:0] * r3_g2;
            r4_l2y  <= r3_awy[15:0] * r3_g2;
            r4_l1x  <= r3_awx[15:0] * r3_g1;
            r4_l1y  <= r3_awy[15:0] * r3_g1;
            r4_swx  <= r3_swx;
            r4_swy  <= r3_swy;
            r4_appr <= r3_c.appr;
            r4_vel  <= r3_c.vel;

            r5_cmx  <= r4_cmx;
            r5_cmy  <= r4_cmy;
            r5_d2x  <= f_sgn(r4_swx, w_s2x[68:31]);
            r5_d2y  <= f_sgn(r4_swy, w_s2y[68:31]);
            r5_d1x  <= f_sgn(r4_swx, w_s1x[68:31]);
            r5_d1y  <= f_sgn(r4_swy, w_s1y[68:31]);
            r5_appr <= r4_appr;
            r5_vel  <= r4_vel;

            r6_res.appr <= r5_appr;
            if (r5_appr) begin
                r6_res.n1x <= f_sat32(40'(r5_cmx) + 40'(r5_d2x));
                r6_res.n1y <= f_sat32(40'(r5_cmy) + 40'(r5_d2y));
                r6_res.n2x <= f_sat32(40'(r5_cmx) - 40'(r5_d1x));
                r6_res.n2y <= f_sat32(40'(r5_cmy) - 40'(r5_d1y));
            end else begin
                r6_res.n1x <= r5_vel.v1x;
                r6_res.n1y <= r5_vel.v1y;
                r6_res.n2x <= r5_vel.v2x;
                r6_res.n2y <= r5_vel.v2y;
            end
        end
    end

    assign o_valid  = r6_vld;
    assign o_result = r6_res;

endmodule

// ----- design/disc_collision_response.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disc_collision_response
// Elastic two-disc collision response with restitution, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Pipeline: 7 front stages, 34 divider stages, 6 back stages from s_axis item
// accept to m_axis_tvalid.
// Throughput: one item per cycle while the output buffer is not full; the 34-stage divider pipeline sets depth.
// The 2-entry output buffer lets the pipeline keep accepting while one
// result waits. Synchronous active-low reset clears all valid bits, empties
// the output buffer and sets restitution to 1.0.
module disc_collision_response (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,    // restitution_q15
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] first_center_x, [63:32] first_center_y, [95:64] first_velocity_x,
    // [127:96] first_velocity_y, [158:128] first_radius,
    // [190:159] second_center_x, [222:191] second_center_y,
    // [254:223] second_velocity_x, [286:255] second_velocity_y,
    // [317:287] second_radius, [319:318] zero
    input  logic [319:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] new_first_velocity_x, [63:32] new_first_velocity_y,
    // [95:64] new_second_velocity_x, [127:96] new_second_velocity_y
    output logic [127:0] m_axis_tdata,
    output logic [0:0]   m_axis_tuser    // [0] approaching
);
    import dcr_pkg::*;

    logic [15:0]       r_restitution;
    logic [1:0]        r_cnt;
    t_result           r_q0, r_q1;

    logic              w_en, w_push, w_pop;
    t_pair             w_pair;
    logic              w_fvld;
    t_front            w_front;
    logic              w_vld_qx, w_vld_qy, w_vld_m;
    t_carry            w_carry;
    logic [DIV_QW-1:0] w_qx, w_qy, w_f2;
    logic              w_sgny, w_mzero;
    logic              w_bvld;
    t_result           w_res;

    assign w_en          = (r_cnt != 2'd2);
    assign s_axis_tready = w_en;

    assign w_pair.c1x = s_axis_tdata[31:0];
    assign w_pair.c1y = s_axis_tdata[63:32];
    assign w_pair.v1x = s_axis_tdata[95:64];
    assign w_pair.v1y = s_axis_tdata[127:96];
    assign w_pair.r1  = s_axis_tdata[158:128];
    assign w_pair.c2x = s_axis_tdata[190:159];
    assign w_pair.c2y = s_axis_tdata[222:191];
    assign w_pair.v2x = s_axis_tdata[254:223];
    assign w_pair.v2y = s_axis_tdata[286:255];
    assign w_pair.r2  = s_axis_tdata[317:287];

    dcr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_pair  (w_pair),
        .o_valid (w_fvld),
        .o_front (w_front)
    );

    dcr_div #(.NW(Q_NW), .DW(Q_DW), .QW(DIV_QW), .PW($bits(t_carry))) u_div_qx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fvld),
        .i_num   (w_front.nqx),
        .i_den   (w_front.dq),
        .i_pl    (w_front.carry),
        .o_valid (w_vld_qx),
        .o_quot  (w_qx),
        .o_pl    (w_carry)
    );

    dcr_div #(.NW(Q_NW), .DW(Q_DW), .QW(DIV_QW), .PW(1)) u_div_qy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fvld),
        .i_num   (w_front.nqy),
        .i_den   (w_front.dq),
        .i_pl    (w_front.sgny),
        .o_valid (w_vld_qy),
        .o_quot  (w_qy),
        .o_pl    (w_sgny)
    );

    dcr_div #(.NW(M_NW), .DW(M_DW), .QW(DIV_QW), .PW(1)) u_div_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fvld),
        .i_num   (w_front.nm),
        .i_den   (w_front.dm),
        .i_pl    (w_front.mzero),
        .o_valid (w_vld_m),
        .o_quot  (w_f2),
        .o_pl    (w_mzero)
    );

    dcr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_vld_qx),
        .i_carry       (w_carry),
        .i_qx          (w_qx),
        .i_qy          (w_qy),
        .i_sgny        (w_sgny),
        .i_f2          (w_f2),
        .i_mzero       (w_mzero),
        .i_restitution (r_restitution),
        .o_valid       (w_bvld),
        .o_result      (w_res)
    );

    assign w_push = w_bvld & w_en;
    assign w_pop  = (r_cnt != 2'd0) & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution <= E_ONE;
        end else if (i_cfg_we) begin
            r_restitution <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_push && !w_pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && !w_pop) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= w_res;
            end else begin
                r_q1 <= w_res;
            end
        end else if (!w_push && w_pop) begin
            r_q0 <= r_q1;
        end else if (w_push && w_pop) begin
            if (r_cnt == 2'd1) begin
                r_q0 <= w_res;
            end else begin
                r_q0 <= r_q1;
                r_q1 <= w_res;
            end
        end
    end

    assign m_axis_tvalid        = (r_cnt != 2'd0);
    assign m_axis_tdata[31:0]   = r_q0.n1x;
    assign m_axis_tdata[63:32]  = r_q0.n1y;
    assign m_axis_tdata[95:64]  = r_q0.n2x;
    assign m_axis_tdata[127:96] = r_q0.n2y;
    assign m_axis_tuser[0]      = r_q0.appr;

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld_qx == w_vld_qy) && (w_vld_qx == w_vld_m))
        else $error("divider lanes out of step");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_buf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("output buffer lost an item");

endmodule
